// ----- design/bir_pkg.sv -----
// ----------------------------------------------------------------------------
// bir_pkg
// Shared constants, types and codes of the bilinear image resampler.
// ----------------------------------------------------------------------------
package bir_pkg;

  localparam int MAX_IN_WIDTH  = 128;
  localparam int MAX_IN_HEIGHT = 128;
  localparam int FRAC_BITS     = 16;

  localparam int PIX_W      = 16;
  localparam int COORD_W    = 12;
  localparam int STEP_W     = 24;
  localparam int STEP_FRAC  = 16;
  localparam int SIZE_W     = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam int POS_W  = STEP_W + COORD_W;
  localparam int PROD_W = STEP_W + COORD_W + 1;
  localparam int ONE_Q16 = 1 << STEP_FRAC;

  localparam int FRAC_ONE = 1 << FRAC_BITS;
  localparam int TOP_W    = PIX_W + FRAC_BITS + 1;
  localparam int ACC_W    = TOP_W + FRAC_BITS + 1;

  localparam int BANK_CB = ($clog2((MAX_IN_WIDTH + 1) / 2) > 0) ?
                           $clog2((MAX_IN_WIDTH + 1) / 2) : 1;
  localparam int BANK_RB = ($clog2((MAX_IN_HEIGHT + 1) / 2) > 0) ?
                           $clog2((MAX_IN_HEIGHT + 1) / 2) : 1;
  localparam int BANK_AW    = BANK_RB + BANK_CB;
  localparam int BANK_DEPTH = 1 << BANK_AW;

  localparam logic [PIX_W-1:0] PIX_BIAS = 16'h8000;
  localparam logic [PIX_W-1:0] PIX_MAX  = 16'hFFFF;

  typedef logic [FRAC_BITS-1:0] frac_t;
  typedef logic [FRAC_BITS:0]   wgt_t;
  typedef logic [POS_W-1:0]     pos_t;
  typedef logic [PROD_W-1:0]    prod_t;
  typedef logic [TOP_W-1:0]     top_t;
  typedef logic [ACC_W-1:0]     acc_t;

  typedef enum logic {
    OP_WRITE   = 1'b0,
    OP_REQUEST = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IN_WIDTH      = 3'd0,
    CFG_IN_HEIGHT     = 3'd1,
    CFG_OUT_WIDTH     = 3'd2,
    CFG_OUT_HEIGHT    = 3'd3,
    CFG_STEP_X        = 3'd4,
    CFG_STEP_Y        = 3'd5,
    CFG_ALIGN_CORNERS = 3'd6,
    CFG_ALIGN_ORIGIN  = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [SIZE_W-1:0] lo;
    logic [SIZE_W-1:0] hi;
    frac_t             frac;
    logic              same;
  } taps_t;

  typedef struct packed {
    logic [PIX_W-1:0] tl;
    logic [PIX_W-1:0] tr;
    logic [PIX_W-1:0] bl;
    logic [PIX_W-1:0] br;
  } quad_t;

endpackage

// ----- design/bir_axis_map.sv -----
// ----------------------------------------------------------------------------
// bir_axis_map
// Three-stage mapping of an output index to two source taps and a weight.
// ----------------------------------------------------------------------------
module bir_axis_map (
  input  logic                          clk,
  input  logic                          en,
  input  logic [bir_pkg::COORD_W-1:0]   idx,
  input  logic [bir_pkg::STEP_W-1:0]    step,
  input  logic                          half,
  input  logic [bir_pkg::SIZE_W-1:0]    size,
  output bir_pkg::taps_t                taps
);

  logic [bir_pkg::COORD_W:0] mul_in;
  bir_pkg::prod_t            prod_nxt;
  bir_pkg::prod_t            prod_r;
  bir_pkg::pos_t             coord_nxt;
  bir_pkg::pos_t             coord_r;
  bir_pkg::pos_t             limit;
  bir_pkg::pos_t             clamped;
  logic [bir_pkg::SIZE_W-1:0] last;
  logic [bir_pkg::SIZE_W-1:0] lo;
  bir_pkg::taps_t            taps_nxt;
  bir_pkg::taps_t            taps_r;

  // stage 1: step times index, or times 2*index+1 for pixel centers
  assign mul_in   = half ? {idx, 1'b1} : {1'b0, idx};
  assign prod_nxt = bir_pkg::prod_t'(step) * bir_pkg::prod_t'(mul_in);

  // stage 2: half-pixel offset, floored at zero
  always_comb begin
    if (!half) begin
      coord_nxt = prod_r[bir_pkg::POS_W-1:0];
    end else if (prod_r <= bir_pkg::prod_t'(bir_pkg::ONE_Q16)) begin
      coord_nxt = '0;
    end else begin
      coord_nxt = bir_pkg::pos_t'((prod_r - bir_pkg::prod_t'(bir_pkg::ONE_Q16)) >> 1);
    end
  end

  // stage 3: clamp to the last pixel and split into taps
  always_comb begin
    last          = size - bir_pkg::SIZE_W'(1);
    limit         = bir_pkg::pos_t'({last, bir_pkg::STEP_FRAC'(0)});
    clamped       = (coord_r > limit) ? limit : coord_r;
    lo            = clamped[bir_pkg::STEP_FRAC +: bir_pkg::SIZE_W];
    taps_nxt.lo   = lo;
    taps_nxt.same = (lo == last);
    taps_nxt.hi   = (lo == last) ? lo : lo + bir_pkg::SIZE_W'(1);
    taps_nxt.frac = clamped[bir_pkg::STEP_FRAC-1 -: bir_pkg::FRAC_BITS];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r  <= prod_nxt;
      coord_r <= coord_nxt;
      taps_r  <= taps_nxt;
    end
  end

  assign taps = taps_r;

endmodule

// ----- design/bir_frame_store.sv -----
// ----------------------------------------------------------------------------
// bir_frame_store
// Source frame held in four banks by row and column parity, so that the
// four taps of one output pixel are read together.
// ----------------------------------------------------------------------------
module bir_frame_store (
  input  logic                          clk,
  input  logic                          en,
  input  logic                          wr_en,
  input  logic [bir_pkg::COORD_W-1:0]   wr_col,
  input  logic [bir_pkg::COORD_W-1:0]   wr_row,
  input  logic [bir_pkg::PIX_W-1:0]     wr_data,
  input  bir_pkg::taps_t                tx,
  input  bir_pkg::taps_t                ty,
  output bir_pkg::quad_t                q
);

  logic [bir_pkg::PIX_W-1:0]   rd_q_r [2][2];
  logic                        xlo0_r;
  logic                        ylo0_r;
  logic                        xsame_r;
  logic                        ysame_r;
  logic [bir_pkg::BANK_AW-1:0] wr_addr;

  assign wr_addr = {wr_row[bir_pkg::BANK_RB:1], wr_col[bir_pkg::BANK_CB:1]};

  for (genvar br = 0; br < 2; br++) begin : g_row
    for (genvar bc = 0; bc < 2; bc++) begin : g_col
      logic [bir_pkg::PIX_W-1:0]   mem [bir_pkg::BANK_DEPTH];
      logic [bir_pkg::SIZE_W-1:0]  rsel;
      logic [bir_pkg::SIZE_W-1:0]  csel;
      logic [bir_pkg::COORD_W-1:0] rsel_ext;
      logic [bir_pkg::COORD_W-1:0] csel_ext;
      logic [bir_pkg::BANK_AW-1:0] rd_addr;

      // pick whichever tap has this bank's parity
      always_comb begin
        rsel     = (ty.lo[0] == 1'(br)) ? ty.lo : ty.hi;
        csel     = (tx.lo[0] == 1'(bc)) ? tx.lo : tx.hi;
        rsel_ext = bir_pkg::COORD_W'(rsel);
        csel_ext = bir_pkg::COORD_W'(csel);
        rd_addr  = {rsel_ext[bir_pkg::BANK_RB:1], csel_ext[bir_pkg::BANK_CB:1]};
      end

      always_ff @(posedge clk) begin
        if (en) begin
          if (wr_en && (wr_row[0] == 1'(br)) && (wr_col[0] == 1'(bc))) begin
            mem[wr_addr] <= wr_data;
          end
          rd_q_r[br][bc] <= mem[rd_addr];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xlo0_r  <= tx.lo[0];
      ylo0_r  <= ty.lo[0];
      xsame_r <= tx.same;
      ysame_r <= ty.same;
    end
  end

  // edge taps reuse the low tap
  always_comb begin
    q.tl = rd_q_r[ylo0_r][xlo0_r];
    q.tr = xsame_r ? q.tl : rd_q_r[ylo0_r][~xlo0_r];
    q.bl = ysame_r ? q.tl : rd_q_r[~ylo0_r][xlo0_r];
    if (ysame_r) begin
      q.br = q.tr;
    end else if (xsame_r) begin
      q.br = q.bl;
    end else begin
      q.br = rd_q_r[~ylo0_r][~xlo0_r];
    end
  end

endmodule

// ----- design/bir_blend.sv -----
// ----------------------------------------------------------------------------
// bir_blend
// Three-stage weighted blend: horizontal pass, vertical products, rounding.
// ----------------------------------------------------------------------------
module bir_blend (
  input  logic                      clk,
  input  logic                      en,
  input  bir_pkg::quad_t            taps,
  input  bir_pkg::frac_t            fx,
  input  bir_pkg::frac_t            fy,
  output logic [bir_pkg::PIX_W-1:0] pixel
);

  logic [bir_pkg::PIX_W-1:0] a_tl;
  logic [bir_pkg::PIX_W-1:0] a_tr;
  logic [bir_pkg::PIX_W-1:0] a_bl;
  logic [bir_pkg::PIX_W-1:0] a_br;
  bir_pkg::wgt_t             wx0;
  bir_pkg::wgt_t             wx1;
  bir_pkg::wgt_t             wy0;
  bir_pkg::wgt_t             wy1;
  bir_pkg::top_t             top_nxt;
  bir_pkg::top_t             bot_nxt;
  bir_pkg::top_t             top_r;
  bir_pkg::top_t             bot_r;
  bir_pkg::frac_t            fy_r;
  bir_pkg::acc_t             pt_nxt;
  bir_pkg::acc_t             pb_nxt;
  bir_pkg::acc_t             pt_r;
  bir_pkg::acc_t             pb_r;
  bir_pkg::acc_t             sum;
  bir_pkg::acc_t             quo;
  logic [bir_pkg::PIX_W-1:0] pixel_nxt;
  logic [bir_pkg::PIX_W-1:0] pixel_r;

  // stage 5: blend across columns on biased pixels
  always_comb begin
    a_tl    = taps.tl ^ bir_pkg::PIX_BIAS;
    a_tr    = taps.tr ^ bir_pkg::PIX_BIAS;
    a_bl    = taps.bl ^ bir_pkg::PIX_BIAS;
    a_br    = taps.br ^ bir_pkg::PIX_BIAS;
    wx1     = bir_pkg::wgt_t'(fx);
    wx0     = bir_pkg::wgt_t'(bir_pkg::FRAC_ONE) - wx1;
    top_nxt = bir_pkg::top_t'(a_tl) * bir_pkg::top_t'(wx0)
            + bir_pkg::top_t'(a_tr) * bir_pkg::top_t'(wx1);
    bot_nxt = bir_pkg::top_t'(a_bl) * bir_pkg::top_t'(wx0)
            + bir_pkg::top_t'(a_br) * bir_pkg::top_t'(wx1);
  end

  // stage 6: row weights
  always_comb begin
    wy1    = bir_pkg::wgt_t'(fy_r);
    wy0    = bir_pkg::wgt_t'(bir_pkg::FRAC_ONE) - wy1;
    pt_nxt = bir_pkg::acc_t'(top_r) * bir_pkg::acc_t'(wy0);
    pb_nxt = bir_pkg::acc_t'(bot_r) * bir_pkg::acc_t'(wy1);
  end

  // stage 7: round half up, saturate, remove bias
  always_comb begin
    sum       = pt_r + pb_r + (bir_pkg::acc_t'(1) << (2 * bir_pkg::FRAC_BITS - 1));
    quo       = sum >> (2 * bir_pkg::FRAC_BITS);
    pixel_nxt = ((quo > bir_pkg::acc_t'(bir_pkg::PIX_MAX)) ? bir_pkg::PIX_MAX
                                                            : quo[bir_pkg::PIX_W-1:0])
              ^ bir_pkg::PIX_BIAS;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      top_r   <= top_nxt;
      bot_r   <= bot_nxt;
      fy_r    <= fy;
      pt_r    <= pt_nxt;
      pb_r    <= pb_nxt;
      pixel_r <= pixel_nxt;
    end
  end

  assign pixel = pixel_r;

endmodule

// ----- design/bilinear_image_resampler_unit.sv -----
// ----------------------------------------------------------------------------
// bilinear_image_resampler_unit
// Takes one request per clock, a source pixel write or an output pixel
// request, while the output side keeps taking results, and returns a result
// for each output pixel request. The pipeline has seven stages: three
// stages map each axis (step multiply, half-pixel offset, clamp and tap
// split), one stage reads the frame store, and three stages blend (column
// pass, row multiplies, rounding). The frame store is split into four banks
// by row and column parity, so the four neighbours of any source position
// come out in one read. Writes pass through the same pipeline and land in
// the store in request order. When a result waits at the output, the whole
// pipeline holds. The store has no clearing pass; entries read before they
// are written are undefined.
// ----------------------------------------------------------------------------
module bilinear_image_resampler_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [0:0]                       in_op,
  input  logic [bir_pkg::COORD_W-1:0]      in_col,
  input  logic [bir_pkg::COORD_W-1:0]      in_row,
  input  logic signed [bir_pkg::PIX_W-1:0] in_pixel_in,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [bir_pkg::COORD_W-1:0]      out_col,
  output logic [bir_pkg::COORD_W-1:0]      out_row,
  output logic signed [bir_pkg::PIX_W-1:0] out_pixel_out,
  input  logic                             cfg_wr_en,
  input  logic [bir_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bir_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  logic [bir_pkg::SIZE_W-1:0] cfg_in_width_r;
  logic [bir_pkg::SIZE_W-1:0] cfg_in_height_r;
  logic [bir_pkg::STEP_W-1:0] cfg_step_x_r;
  logic [bir_pkg::STEP_W-1:0] cfg_step_y_r;
  logic                       cfg_align_corners_r;
  logic                       cfg_align_origin_r;

  logic [bir_pkg::SIZE_W-1:0] eff_w;
  logic [bir_pkg::SIZE_W-1:0] eff_h;
  logic                       half;
  logic                       adv;
  logic                       wr_en;

  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r;
  bir_pkg::op_t op1_r, op2_r, op3_r;
  logic [bir_pkg::COORD_W-1:0] col1_r, col2_r, col3_r, col4_r, col5_r, col6_r, col7_r;
  logic [bir_pkg::COORD_W-1:0] row1_r, row2_r, row3_r, row4_r, row5_r, row6_r, row7_r;
  logic [bir_pkg::PIX_W-1:0]   pix1_r, pix2_r, pix3_r;
  bir_pkg::frac_t              fx4_r;
  bir_pkg::frac_t              fy4_r;

  bir_pkg::taps_t              tx_taps;
  bir_pkg::taps_t              ty_taps;
  bir_pkg::quad_t              quad;
  logic [bir_pkg::PIX_W-1:0]   pixel;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_in_width_r      <= bir_pkg::SIZE_W'(128);
      cfg_in_height_r     <= bir_pkg::SIZE_W'(128);
      cfg_step_x_r        <= bir_pkg::STEP_W'(bir_pkg::ONE_Q16);
      cfg_step_y_r        <= bir_pkg::STEP_W'(bir_pkg::ONE_Q16);
      cfg_align_corners_r <= 1'b0;
      cfg_align_origin_r  <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (bir_pkg::cfg_idx_t'(cfg_index))
        bir_pkg::CFG_IN_WIDTH:      cfg_in_width_r      <= cfg_wdata[bir_pkg::SIZE_W-1:0];
        bir_pkg::CFG_IN_HEIGHT:     cfg_in_height_r     <= cfg_wdata[bir_pkg::SIZE_W-1:0];
        bir_pkg::CFG_OUT_WIDTH:     ;
        bir_pkg::CFG_OUT_HEIGHT:    ;
        bir_pkg::CFG_STEP_X:        cfg_step_x_r        <= cfg_wdata[bir_pkg::STEP_W-1:0];
        bir_pkg::CFG_STEP_Y:        cfg_step_y_r        <= cfg_wdata[bir_pkg::STEP_W-1:0];
        bir_pkg::CFG_ALIGN_CORNERS: cfg_align_corners_r <= cfg_wdata[0];
        bir_pkg::CFG_ALIGN_ORIGIN:  cfg_align_origin_r  <= cfg_wdata[0];
      endcase
    end
  end

  // source size limited to 1..max
  always_comb begin
    priority if (cfg_in_width_r == '0) begin
      eff_w = bir_pkg::SIZE_W'(1);
    end else if (32'(cfg_in_width_r) > bir_pkg::MAX_IN_WIDTH) begin
      eff_w = bir_pkg::SIZE_W'(bir_pkg::MAX_IN_WIDTH);
    end else begin
      eff_w = cfg_in_width_r;
    end
    priority if (cfg_in_height_r == '0) begin
      eff_h = bir_pkg::SIZE_W'(1);
    end else if (32'(cfg_in_height_r) > bir_pkg::MAX_IN_HEIGHT) begin
      eff_h = bir_pkg::SIZE_W'(bir_pkg::MAX_IN_HEIGHT);
    end else begin
      eff_h = cfg_in_height_r;
    end
  end

  assign half     = !(cfg_align_corners_r || cfg_align_origin_r);
  assign adv      = !v7_r || out_ready;
  assign in_ready = adv;

  // request sideband through the pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r && (op3_r == bir_pkg::OP_REQUEST);
      v5_r <= v4_r;
      v6_r <= v5_r;
      v7_r <= v6_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      op1_r  <= bir_pkg::op_t'(in_op);
      op2_r  <= op1_r;
      op3_r  <= op2_r;
      col1_r <= in_col;
      col2_r <= col1_r;
      col3_r <= col2_r;
      col4_r <= col3_r;
      col5_r <= col4_r;
      col6_r <= col5_r;
      col7_r <= col6_r;
      row1_r <= in_row;
      row2_r <= row1_r;
      row3_r <= row2_r;
      row4_r <= row3_r;
      row5_r <= row4_r;
      row6_r <= row5_r;
      row7_r <= row6_r;
      pix1_r <= in_pixel_in;
      pix2_r <= pix1_r;
      pix3_r <= pix2_r;
      fx4_r  <= tx_taps.frac;
      fy4_r  <= ty_taps.frac;
    end
  end

  // writes outside the store are dropped
  assign wr_en = v3_r && (op3_r == bir_pkg::OP_WRITE)
              && (col3_r < bir_pkg::COORD_W'(bir_pkg::MAX_IN_WIDTH))
              && (row3_r < bir_pkg::COORD_W'(bir_pkg::MAX_IN_HEIGHT));

  bir_axis_map u_map_x (
    .clk  (clk),
    .en   (adv),
    .idx  (in_col),
    .step (cfg_step_x_r),
    .half (half),
    .size (eff_w),
    .taps (tx_taps)
  );

  bir_axis_map u_map_y (
    .clk  (clk),
    .en   (adv),
    .idx  (in_row),
    .step (cfg_step_y_r),
    .half (half),
    .size (eff_h),
    .taps (ty_taps)
  );

  bir_frame_store u_store (
    .clk     (clk),
    .en      (adv),
    .wr_en   (wr_en),
    .wr_col  (col3_r),
    .wr_row  (row3_r),
    .wr_data (pix3_r),
    .tx      (tx_taps),
    .ty      (ty_taps),
    .q       (quad)
  );

  bir_blend u_blend (
    .clk   (clk),
    .en    (adv),
    .taps  (quad),
    .fx    (fx4_r),
    .fy    (fy4_r),
    .pixel (pixel)
  );

  assign out_valid     = v7_r;
  assign out_col       = col7_r;
  assign out_row       = row7_r;
  assign out_pixel_out = pixel;

  // pipeline holds still while the output waits
  assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable({v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r}))
    else $error("pipeline valid bits moved during a stall");

  // taps stay inside the source image
  assert property (@(posedge clk) disable iff (!rst_n)
    v3_r && (op3_r == bir_pkg::OP_REQUEST) |->
      (tx_taps.lo <= tx_taps.hi) && (tx_taps.hi < eff_w) &&
      (ty_taps.lo <= ty_taps.hi) && (ty_taps.hi < eff_h))
    else $error("tap index outside the source image");

  // a clamped edge tap carries no weight
  assert property (@(posedge clk) disable iff (!rst_n)
    v3_r && (op3_r == bir_pkg::OP_REQUEST) |->
      (!tx_taps.same || (tx_taps.frac == '0)) &&
      (!ty_taps.same || (ty_taps.frac == '0)))
    else $error("edge tap with nonzero weight");

endmodule

// ----- dv/tb_bilinear_image_resampler_unit.sv -----
// ----------------------------------------------------------------------------
// tb_bilinear_image_resampler_unit
// Self-checking bench for the bilinear image resampler. It loads source pixels
// into the frame store and asks for interpolated output pixels. Each request
// is predicted from a local copy of the store and of the settings, and every
// result is matched in order against that prediction. A short table of
// directed cases comes first: extreme pixels, ignored writes outside the
// store, clamped edges, zero and oversize source sizes, half-pixel offsets
// below zero and very large steps. Then random phases run, each with its own
// settings. Before any request, every source pixel that its taps touch is
// loaded, so no entry is read before it is written. Both sides idle at
// random, and once the output side holds off long enough to fill the
// pipeline.
// ----------------------------------------------------------------------------
module tb_bilinear_image_resampler_unit;

  localparam int STORE_DEPTH  = bir_pkg::MAX_IN_WIDTH * bir_pkg::MAX_IN_HEIGHT;
  localparam int ITEM_GOAL    = 1950;
  localparam int PHASE_ITEMS  = 110;
  localparam int DRAIN_CYCLES = 12;
  localparam int HOLD_CYCLES  = 300;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int IDLE_PCT     = 11;

  typedef struct packed {
    bit                 is_cfg;
    bir_pkg::cfg_idx_t  reg_idx;
    bit [23:0]          data;
    bir_pkg::op_t       op;
    bit [11:0]          col;
    bit [11:0]          row;
    bit [15:0]          pix;
    bit                 typed;
    bit [15:0]          typed_pix;
  } stim_row_t;

  typedef struct {
    bit [11:0] col;
    bit [11:0] row;
    bit [15:0] pix;
  } resampled_t;

  typedef struct {
    int unsigned lo;
    int unsigned hi;
    bit [63:0]   frac;
  } tap_pair_t;

  localparam int DIRECTED_ROWS = 37;

  // extremes, ignored writes, edge clamps, size limits, half-pixel and step cases
  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{0, bir_pkg::CFG_IN_WIDTH, 0, bir_pkg::OP_WRITE, 0, 0, 16'h8000, 0, 0},
    '{0, bir_pkg::CFG_IN_WIDTH, 0, bir_pkg::OP_WRITE, 1, 0, 16'h7FFF, 0, 0},
    '{0, bir_pkg::CFG_IN_WIDTH, 0, bir_pkg::OP_WRITE, 0, 1, 16'h0000, 0, 0},
    '{0, bir_pkg::CFG_IN_WIDTH, 0, bir_pkg::OP_WRITE, 1, 1, 16'hFFFF, 0, 0},
    '{0, bir_pkg::CFG_IN_WIDTH, 0, bir_pkg::OP_WRITE, 127, 127, 16'h7FFF, 0, 0},
    '{0, bir_pkg::CFG_IN_WIDTH, 0, bir_pkg::OP_WRITE, 128, 0, 16'h1234, 0, 0},
    '{0, bir_pkg::CFG_IN_WIDTH, 0, bir_pkg::OP_WRITE, 4095, 4095, 16'h5555, 0, 0},
    '{0, bir_pkg::CFG_IN_WIDTH, 0, bir_pkg::OP_WRITE, 5, 128, 16'hAAAA, 0, 0},
    '{0, bir_pkg::CFG_IN_WIDTH, 0, bir_pkg::OP_REQUEST, 0, 0, 0, 1, 16'h8000},
    '{0, bir_pkg::CFG_IN_WIDTH, 0, bir_pkg::OP_REQUEST, 1, 0, 0, 1, 16'h7FFF},
    '{0, bir_pkg::CFG_IN_WIDTH, 0, bir_pkg::OP_REQUEST, 0, 1, 0, 1, 16'h0000},
    '{0, bir_pkg::CFG_IN_WIDTH, 0, bir_pkg::OP_REQUEST, 1, 1, 0, 1, 16'hFFFF},
    '{0, bir_pkg::CFG_IN_WIDTH, 0, bir_pkg::OP_REQUEST, 127, 127, 0, 1, 16'h7FFF},
    '{0, bir_pkg::CFG_IN_WIDTH, 0, bir_pkg::OP_REQUEST, 4095, 4095, 0, 1, 16'h7FFF},
    '{1, bir_pkg::CFG_IN_WIDTH, 24'd0, bir_pkg::OP_WRITE, 0, 0, 0, 0, 0},
    '{1, bir_pkg::CFG_IN_HEIGHT, 24'd0, bir_pkg::OP_WRITE, 0, 0, 0, 0, 0},
    '{0, bir_pkg::CFG_IN_WIDTH, 0, bir_pkg::OP_REQUEST, 5, 7, 0, 1, 16'h8000},
    '{1, bir_pkg::CFG_IN_WIDTH, 24'd255, bir_pkg::OP_WRITE, 0, 0, 0, 0, 0},
    '{1, bir_pkg::CFG_IN_HEIGHT, 24'd200, bir_pkg::OP_WRITE, 0, 0, 0, 0, 0},
    '{0, bir_pkg::CFG_IN_WIDTH, 0, bir_pkg::OP_REQUEST, 4095, 3, 0, 0, 0},
    '{1, bir_pkg::CFG_IN_WIDTH, 24'd128, bir_pkg::OP_WRITE, 0, 0, 0, 0, 0},
    '{1, bir_pkg::CFG_IN_HEIGHT, 24'd128, bir_pkg::OP_WRITE, 0, 0, 0, 0, 0},
    '{1, bir_pkg::CFG_STEP_X, 24'h008000, bir_pkg::OP_WRITE, 0, 0, 0, 0, 0},
    '{1, bir_pkg::CFG_STEP_Y, 24'h008000, bir_pkg::OP_WRITE, 0, 0, 0, 0, 0},
    '{0, bir_pkg::CFG_IN_WIDTH, 0, bir_pkg::OP_REQUEST, 0, 0, 0, 1, 16'h8000},
    '{0, bir_pkg::CFG_IN_WIDTH, 0, bir_pkg::OP_REQUEST, 3, 1, 0, 0, 0},
    '{1, bir_pkg::CFG_STEP_X, 24'hFFFFFF, bir_pkg::OP_WRITE, 0, 0, 0, 0, 0},
    '{1, bir_pkg::CFG_ALIGN_CORNERS, 24'd1, bir_pkg::OP_WRITE, 0, 0, 0, 0, 0},
    '{0, bir_pkg::CFG_IN_WIDTH, 0, bir_pkg::OP_REQUEST, 1, 0, 0, 0, 0},
    '{1, bir_pkg::CFG_ALIGN_CORNERS, 24'd0, bir_pkg::OP_WRITE, 0, 0, 0, 0, 0},
    '{1, bir_pkg::CFG_ALIGN_ORIGIN, 24'd1, bir_pkg::OP_WRITE, 0, 0, 0, 0, 0},
    '{1, bir_pkg::CFG_STEP_X, 24'h018000, bir_pkg::OP_WRITE, 0, 0, 0, 0, 0},
    '{1, bir_pkg::CFG_STEP_Y, 24'h010000, bir_pkg::OP_WRITE, 0, 0, 0, 0, 0},
    '{0, bir_pkg::CFG_IN_WIDTH, 0, bir_pkg::OP_REQUEST, 1, 1, 0, 0, 0},
    '{1, bir_pkg::CFG_OUT_WIDTH, 24'd1, bir_pkg::OP_WRITE, 0, 0, 0, 0, 0},
    '{1, bir_pkg::CFG_OUT_HEIGHT, 24'd4095, bir_pkg::OP_WRITE, 0, 0, 0, 0, 0},
    '{0, bir_pkg::CFG_IN_WIDTH, 0, bir_pkg::OP_REQUEST, 3, 0, 0, 0, 0}
  };

  logic                                 clk = 1'b0;
  logic                                 rst_n = 1'b0;
  logic                                 in_valid = 1'b0;
  logic                                 in_ready;
  logic [0:0]                           in_op = 1'b0;
  logic [bir_pkg::COORD_W-1:0]          in_col = '0;
  logic [bir_pkg::COORD_W-1:0]          in_row = '0;
  logic signed [bir_pkg::PIX_W-1:0]     in_pixel_in = '0;
  logic                                 out_valid;
  logic                                 out_ready = 1'b0;
  logic [bir_pkg::COORD_W-1:0]          out_col;
  logic [bir_pkg::COORD_W-1:0]          out_row;
  logic signed [bir_pkg::PIX_W-1:0]     out_pixel_out;
  logic                                 cfg_wr_en = 1'b0;
  logic [bir_pkg::CFG_IDX_W-1:0]        cfg_index = '0;
  logic [bir_pkg::CFG_DATA_W-1:0]       cfg_wdata = '0;

  bilinear_image_resampler_unit u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_op         (in_op),
    .in_col        (in_col),
    .in_row        (in_row),
    .in_pixel_in   (in_pixel_in),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_col       (out_col),
    .out_row       (out_row),
    .out_pixel_out (out_pixel_out),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  always #5 clk = ~clk;

  // local copy of settings and frame store
  bit [7:0]   sh_in_width = 8'd128;
  bit [7:0]   sh_in_height = 8'd128;
  bit [23:0]  sh_step_x = 24'h010000;
  bit [23:0]  sh_step_y = 24'h010000;
  bit         sh_align_corners = 1'b0;
  bit         sh_align_origin = 1'b0;
  bit [15:0]  src_frame [STORE_DEPTH];
  bit         pix_written [STORE_DEPTH];

  resampled_t  expected_pixels [$];
  int unsigned error_count = 0;
  int unsigned checked_count = 0;
  int unsigned items_sent = 0;
  int unsigned requests_sent = 0;
  int unsigned settings_count = 0;
  int unsigned cycle_count = 0;

  bit          no_idle = 1'b0;
  bit          want_hold = 1'b0;
  bit          hold_served = 1'b0;
  int unsigned hold_left = 0;

  function automatic int unsigned eff_dim(bit [7:0] v, int unsigned maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  function automatic tap_pair_t map_source_axis(bit [11:0] idx, bit [23:0] step,
                                                int unsigned size);
    tap_pair_t t;
    bit [63:0] pos;
    bit [63:0] lim;
    bit [63:0] twice;
    lim = 64'(size - 1) << bir_pkg::STEP_FRAC;
    if (sh_align_corners || sh_align_origin) begin
      pos = 64'(step) * 64'(idx);
    end else begin
      twice = 64'(step) * (64'(idx) * 2 + 1);
      pos = (twice <= bir_pkg::ONE_Q16) ? 64'd0 : (twice - bir_pkg::ONE_Q16) >> 1;
    end
    if (pos > lim) pos = lim;
    t.lo = int'(pos >> bir_pkg::STEP_FRAC);
    t.hi = (t.lo + 1 < size) ? t.lo + 1 : size - 1;
    t.frac = (pos & 64'hFFFF) >> (bir_pkg::STEP_FRAC - bir_pkg::FRAC_BITS);
    return t;
  endfunction

  function automatic bit [63:0] biased_tap(int unsigned r, int unsigned c);
    return 64'(src_frame[r * bir_pkg::MAX_IN_WIDTH + c] ^ bir_pkg::PIX_BIAS);
  endfunction

  function automatic bit [15:0] interp_pixel(bit [11:0] col, bit [11:0] row);
    tap_pair_t tx;
    tap_pair_t ty;
    bit [63:0] one;
    bit [63:0] top;
    bit [63:0] bot;
    bit [63:0] acc;
    tx = map_source_axis(col, sh_step_x, eff_dim(sh_in_width, bir_pkg::MAX_IN_WIDTH));
    ty = map_source_axis(row, sh_step_y, eff_dim(sh_in_height, bir_pkg::MAX_IN_HEIGHT));
    one = 64'd1 << bir_pkg::FRAC_BITS;
    top = biased_tap(ty.lo, tx.lo) * (one - tx.frac) + biased_tap(ty.lo, tx.hi) * tx.frac;
    bot = biased_tap(ty.hi, tx.lo) * (one - tx.frac) + biased_tap(ty.hi, tx.hi) * tx.frac;
    acc = top * (one - ty.frac) + bot * ty.frac;
    acc = (acc + (64'd1 << (2 * bir_pkg::FRAC_BITS - 1))) >> (2 * bir_pkg::FRAC_BITS);
    if (acc > 64'hFFFF) acc = 64'hFFFF;
    return acc[15:0] ^ bir_pkg::PIX_BIAS;
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH @%0d: %s", cycle_count, msg);
    error_count++;
  endtask

  task automatic send_item(bir_pkg::op_t op, bit [11:0] col, bit [11:0] row,
                           bit [15:0] pix, bit typed, bit [15:0] typed_pix);
    resampled_t e;
    while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_col <= col;
    in_row <= row;
    in_pixel_in <= pix;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    if (op == bir_pkg::OP_WRITE) begin
      if (col < bir_pkg::MAX_IN_WIDTH && row < bir_pkg::MAX_IN_HEIGHT) begin
        src_frame[row * bir_pkg::MAX_IN_WIDTH + col] = pix;
      end
    end else begin
      e.col = col;
      e.row = row;
      e.pix = typed ? typed_pix : interp_pixel(col, row);
      expected_pixels.insert(expected_pixels.size(), e);
      requests_sent++;
    end
  endtask

  task automatic write_pixel(bit [11:0] col, bit [11:0] row, bit [15:0] pix);
    if (col < bir_pkg::MAX_IN_WIDTH && row < bir_pkg::MAX_IN_HEIGHT) begin
      pix_written[row * bir_pkg::MAX_IN_WIDTH + col] = 1'b1;
    end
    send_item(bir_pkg::OP_WRITE, col, row, pix, 1'b0, 16'h0);
  endtask

  // loads every unwritten tap of a request first
  task automatic request_pixel(bit [11:0] col, bit [11:0] row, bit typed,
                               bit [15:0] typed_pix);
    tap_pair_t   tx;
    tap_pair_t   ty;
    int unsigned rs [2];
    int unsigned cs [2];
    tx = map_source_axis(col, sh_step_x, eff_dim(sh_in_width, bir_pkg::MAX_IN_WIDTH));
    ty = map_source_axis(row, sh_step_y, eff_dim(sh_in_height, bir_pkg::MAX_IN_HEIGHT));
    rs = '{ty.lo, ty.hi};
    cs = '{tx.lo, tx.hi};
    for (int i = 0; i < 2; i++) begin
      for (int j = 0; j < 2; j++) begin
        if (!pix_written[rs[i] * bir_pkg::MAX_IN_WIDTH + cs[j]]) begin
          write_pixel(12'(cs[j]), 12'(rs[i]), 16'($urandom));
        end
      end
    end
    send_item(bir_pkg::OP_REQUEST, col, row, 16'($urandom), typed, typed_pix);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(bir_pkg::cfg_idx_t idx, bit [23:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      bir_pkg::CFG_IN_WIDTH:      sh_in_width = data[7:0];
      bir_pkg::CFG_IN_HEIGHT:     sh_in_height = data[7:0];
      bir_pkg::CFG_STEP_X:        sh_step_x = data;
      bir_pkg::CFG_STEP_Y:        sh_step_y = data;
      bir_pkg::CFG_ALIGN_CORNERS: sh_align_corners = data[0];
      bir_pkg::CFG_ALIGN_ORIGIN:  sh_align_origin = data[0];
      default: ;
    endcase
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  function automatic bit [23:0] pick_size();
    case ($urandom_range(0, 9))
      0: return 24'd0;
      1: return 24'd1;
      2: return 24'd128;
      3: return 24'd255;
      default: return 24'($urandom_range(2, 16));
    endcase
  endfunction

  function automatic bit [23:0] pick_step();
    case ($urandom_range(0, 9))
      0: return 24'h000000;
      1: return 24'h800000;
      2: return 24'hFFFFFF;
      3: return 24'h010000;
      default: return 24'($urandom_range(24'h002000, 24'h030000));
    endcase
  endfunction

  function automatic bit [23:0] pick_out_size();
    case ($urandom_range(0, 3))
      0: return 24'd1;
      1: return 24'd4095;
      default: return 24'($urandom_range(1, 4095));
    endcase
  endfunction

  // output side: random stalls plus one long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (want_hold && !hold_served) begin
      out_ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_served <= 1'b1;
    end else begin
      out_ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin : check_results
    resampled_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_pixels.size() == 0) begin
        report_mismatch($sformatf("result col %0d row %0d with no request pending",
                                  out_col, out_row));
      end else begin
        e = expected_pixels.pop_front();
        if (out_col !== e.col || out_row !== e.row || out_pixel_out !== e.pix) begin
          report_mismatch($sformatf("got col %0d row %0d pix %h, exp col %0d row %0d pix %h",
                                    out_col, out_row, out_pixel_out, e.col, e.row, e.pix));
        end
        checked_count++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               expected_pixels.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int unsigned w;
    int unsigned h;
    int unsigned sel;
    int unsigned phase_idx;
    bit [11:0]   col;
    bit [11:0]   row;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      if (directed_rows[i].is_cfg) begin
        if (i == 0 || !directed_rows[i - 1].is_cfg) wait_idle();
        write_reg(directed_rows[i].reg_idx, directed_rows[i].data);
      end else if (directed_rows[i].op == bir_pkg::OP_WRITE) begin
        write_pixel(directed_rows[i].col, directed_rows[i].row, directed_rows[i].pix);
      end else begin
        request_pixel(directed_rows[i].col, directed_rows[i].row, directed_rows[i].typed,
                      directed_rows[i].typed_pix);
      end
    end

    phase_idx = 0;
    while (items_sent < ITEM_GOAL) begin
      wait_idle();
      write_reg(bir_pkg::CFG_IN_WIDTH, pick_size());
      write_reg(bir_pkg::CFG_IN_HEIGHT, pick_size());
      write_reg(bir_pkg::CFG_OUT_WIDTH, pick_out_size());
      write_reg(bir_pkg::CFG_OUT_HEIGHT, pick_out_size());
      write_reg(bir_pkg::CFG_STEP_X, pick_step());
      write_reg(bir_pkg::CFG_STEP_Y, pick_step());
      write_reg(bir_pkg::CFG_ALIGN_CORNERS, 24'($urandom_range(0, 1)));
      write_reg(bir_pkg::CFG_ALIGN_ORIGIN, 24'($urandom_range(0, 1)));
      settings_count++;
      no_idle <= (phase_idx % 6 == 3);
      if (phase_idx == 2) want_hold <= 1'b1;
      w = eff_dim(sh_in_width, bir_pkg::MAX_IN_WIDTH);
      h = eff_dim(sh_in_height, bir_pkg::MAX_IN_HEIGHT);

      // fresh image plane for small sizes
      if (w * h <= 64) begin
        for (int r = 0; r < h; r++) begin
          for (int c = 0; c < w; c++) write_pixel(12'(c), 12'(r), 16'($urandom));
        end
      end

      for (int k = 0; k < PHASE_ITEMS && items_sent < ITEM_GOAL; k++) begin
        sel = $urandom_range(0, 99);
        if (sel < 65) begin
          if ($urandom_range(0, 9) == 0) begin
            col = 12'($urandom_range(0, 4095));
            row = 12'($urandom_range(0, 4095));
          end else begin
            col = 12'($urandom_range(0, 2 * w + 2));
            row = 12'($urandom_range(0, 2 * h + 2));
          end
          request_pixel(col, row, 1'b0, 16'h0);
        end else if (sel < 92) begin
          write_pixel(12'($urandom_range(0, w - 1)), 12'($urandom_range(0, h - 1)),
                      16'($urandom));
        end else begin
          write_pixel(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
                      16'($urandom));
        end
      end
      phase_idx++;
    end

    wait_idle();
    if (expected_pixels.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", expected_pixels.size()));
    end

    $display("%0d items (%0d pixel requests) over %0d random settings plus directed cases",
             items_sent, requests_sent, settings_count);
    $display("%0d interpolated pixels checked, %0d mismatches, one %0d-cycle output hold",
             checked_count, error_count, HOLD_CYCLES);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/bir_pkg.sv
design/bir_axis_map.sv
design/bir_frame_store.sv
design/bir_blend.sv
design/bilinear_image_resampler_unit.sv
dv/tb_bilinear_image_resampler_unit.sv
